// File: rtl/core/sidx_pkg.sv
// ---------------------------------------------------------------------------
// sidx_pkg
// Shared types and constants of the sync, ID and length framed deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package sidx_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [6:0]  exp_count_t;
    typedef logic [15:0] frame_count_t;

    localparam byte_t      SYNC_FIRST    = 8'hFF;
    localparam byte_t      SYNC_SECOND   = 8'hFE;
    localparam byte_t      DEVICE_ID_RST = 8'd1;
    localparam exp_count_t EXP_COUNT_RST = 7'd38;

    localparam byte_t POS_HUNT    = 8'd0;
    localparam byte_t POS_SYNC2   = 8'd1;
    localparam byte_t POS_ID      = 8'd2;
    localparam byte_t POS_LEN     = 8'd3;
    localparam byte_t POS_PAYLOAD = 8'd4;

    localparam logic REG_DEVICE_ID = 1'b0;
    localparam logic REG_EXP_COUNT = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_SEND  = 4'b0100,
        ST_ERR   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/sidx_ifs.sv
// ---------------------------------------------------------------------------
// sidx_ifs
// Valid/ready channel interfaces for received bytes and deframed words.
// ---------------------------------------------------------------------------
`default_nettype none

interface sidx_in_if;
    logic            valid;
    logic            ready;
    sidx_pkg::byte_t data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface sidx_out_if;
    logic                   valid;
    logic                   ready;
    logic                   item_kind;
    sidx_pkg::byte_t        payload_byte;
    logic                   last_of_frame;
    sidx_pkg::frame_count_t good_frames;
    sidx_pkg::frame_count_t bad_frames;

    modport source (output valid, output item_kind, output payload_byte,
                    output last_of_frame, output good_frames, output bad_frames,
                    input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input last_of_frame, input good_frames, input bad_frames,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/sidx_ram.sv
// ---------------------------------------------------------------------------
// sidx_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sidx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/sync_id_length_xor_deframer.sv
// ---------------------------------------------------------------------------
// sync_id_length_xor_deframer
// Recovers frames of the form FF FE ID LEN payload CHK from a byte stream.
// ---------------------------------------------------------------------------
// Received bytes enter on in_ch, one word per accepted handshake. While idle
// the block takes a byte every cycle and parses it in that cycle; payload
// bytes are written to a buffer RAM and folded into a running XOR.
// When the checksum byte ends a good frame, the block drops ready, reads the
// buffer back and sends the payload on out_ch, one word per cycle while out_ch
// is ready, after a RAM fetch in ST_FETCH, with last_of_frame on the final
// word. A rejected frame or a bad second sync byte sends one error word
// instead, in the next cycle. A good frame thus keeps in_ch stalled through
// the fetch and the payload drain and while the receiver holds ready low;
// the buffer's single read port sets the one word per cycle drain rate. When
// out_ch stalls, the current word is held and no new byte is taken.
// Every word carries the good and bad frame counters, which wrap at 16 bits.
// Reset returns the parser to sync hunting, clears the counters, loads the
// register defaults (device ID 1, expected payload 38) and needs no buffer
// clearing. Write registers over the APB port while idle; nothing enforces it.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_id_length_xor_deframer
    import sidx_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sidx_in_if.sink          in_ch,
    sidx_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int CW = $clog2(MAX_PAYLOAD + 2);

    state_t         state_reg, state_next;
    byte_t          pos_reg, pos_next;
    byte_t          len_reg, len_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    byte_t          xor_reg, xor_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    frame_count_t   good_reg, good_next;
    frame_count_t   bad_reg, bad_next;
    byte_t          dev_id_reg;
    exp_count_t     exp_cnt_reg;

    logic           in_acc;
    logic           out_acc;
    logic           cfg_wr;
    logic           frame_ok;
    logic           send_last;
    logic [AW-1:0]  last_idx;
    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    byte_t          ram_rdata;
    byte_t          b;

    sidx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (in_ch.data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign b        = in_ch.data_byte;
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_acc  = out_ch.valid && out_ch.ready;
    assign last_idx = AW'(cnt_reg - CW'(1));
    assign send_last = (rd_ptr_reg == last_idx);

    assign frame_ok = (pos_reg == len_reg) && (len_reg != 8'd0) &&
                      (cnt_reg >= CW'(1)) && (cnt_reg <= CW'(MAX_PAYLOAD)) &&
                      (7'(cnt_reg) == exp_cnt_reg) && (b == xor_reg);

    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign out_ch.valid         = (state_reg == ST_SEND) || (state_reg == ST_ERR);
    assign out_ch.item_kind     = (state_reg == ST_ERR) ? KIND_ERROR : KIND_PAYLOAD;
    assign out_ch.payload_byte  = (state_reg == ST_SEND) ? ram_rdata : 8'd0;
    assign out_ch.last_of_frame = (state_reg == ST_ERR) || send_last;
    assign out_ch.good_frames   = good_reg;
    assign out_ch.bad_frames    = bad_reg;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        xor_next    = xor_reg;
        rd_ptr_next = rd_ptr_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = rd_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (pos_reg == POS_HUNT)
                    begin
                        len_next = 8'd0;
                        if (b == SYNC_FIRST)
                        begin
                            pos_next = POS_SYNC2;
                        end
                    end
                    else if (pos_reg == POS_SYNC2)
                    begin
                        if (b == SYNC_SECOND)
                        begin
                            pos_next = POS_ID;
                        end
                        else
                        begin
                            pos_next   = POS_HUNT;
                            len_next   = 8'd0;
                            bad_next   = bad_reg + 16'd1;
                            state_next = ST_ERR;
                        end
                    end
                    else if (pos_reg == POS_ID)
                    begin
                        pos_next = (b == dev_id_reg) ? POS_LEN : POS_HUNT;
                        len_next = 8'd0;
                    end
                    else if (pos_reg == POS_LEN)
                    begin
                        len_next = b;
                        pos_next = POS_PAYLOAD;
                        cnt_next = '0;
                        xor_next = 8'd0;
                    end
                    else if (pos_reg < len_reg)
                    begin
                        if (cnt_reg < CW'(MAX_PAYLOAD))
                        begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        else
                        begin
                            cnt_next = CW'(MAX_PAYLOAD + 1);
                        end
                        xor_next = xor_reg ^ b;
                        pos_next = pos_reg + 8'd1;
                    end
                    else
                    begin
                        pos_next = POS_HUNT;
                        len_next = 8'd0;
                        if (frame_ok)
                        begin
                            good_next  = good_reg + 16'd1;
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            bad_next   = bad_reg + 16'd1;
                            state_next = ST_ERR;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                ram_re      = 1'b1;
                ram_raddr   = '0;
                rd_ptr_next = '0;
                state_next  = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_acc)
                begin
                    if (send_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = rd_ptr_reg + AW'(1);
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
            end
            ST_ERR:
            begin
                if (out_acc)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= POS_HUNT;
            len_reg    <= 8'd0;
            cnt_reg    <= '0;
            xor_reg    <= 8'd0;
            rd_ptr_reg <= '0;
            good_reg   <= 16'd0;
            bad_reg    <= 16'd0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            xor_reg    <= xor_next;
            rd_ptr_reg <= rd_ptr_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
        end
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_id_reg  <= DEVICE_ID_RST;
            exp_cnt_reg <= EXP_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_DEVICE_ID: dev_id_reg  <= pwdata[7:0];
                REG_EXP_COUNT: exp_cnt_reg <= pwdata[6:0];
                default:       dev_id_reg  <= dev_id_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DEVICE_ID: prdata = {24'd0, dev_id_reg};
            REG_EXP_COUNT: prdata = {25'd0, exp_cnt_reg};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/sidx_checker.sv
// ---------------------------------------------------------------------------
// sidx_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module sidx_checker
    import sidx_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_ready,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic         item_kind,
    input wire byte_t        payload_byte,
    input wire logic         last_of_frame,
    input wire frame_count_t good_frames,
    input wire frame_count_t bad_frames
);

    // The parser never takes a byte while a word is being sent.
    a_no_input_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while an output word is pending");

    // An error word is always a lone, last word with a zero byte.
    a_error_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (item_kind == KIND_ERROR)) |->
            (last_of_frame && (payload_byte == 8'd0)))
        else $error("malformed error word");

    // The counters do not move while the words of one frame are sent.
    a_counters_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid)) |->
            ($stable(good_frames) && $stable(bad_frames)))
        else $error("frame counters changed within a frame");

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(payload_byte) && $stable(last_of_frame)
             && $stable(item_kind)))
        else $error("stalled output word changed");

endmodule

bind sync_id_length_xor_deframer sidx_checker u_sidx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .item_kind     (out_ch.item_kind),
    .payload_byte  (out_ch.payload_byte),
    .last_of_frame (out_ch.last_of_frame),
    .good_frames   (out_ch.good_frames),
    .bad_frames    (out_ch.bad_frames)
);

`default_nettype wire

// File: dv/tb_sync_id_length_xor_deframer.sv
// ---------------------------------------------------------------------------
// tb_sync_id_length_xor_deframer
// Self-checking testbench of the sync, ID and length framed XOR deframer.
// ---------------------------------------------------------------------------
// Bytes are pushed into in_ch while a parser written here tracks the frame
// state and lists the words that each byte should release. A short stimulus
// table opens the run, covering bad sync, ID mismatch, short and zero-length
// frames and bad checksums. Random phases follow, each with its own register
// setting, made mostly of well-formed frames with random payload, plus some
// corrupted frames and line noise. Both handshake sides idle at random, and
// the receiver stalls once for a long stretch so that the block backs up.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_sync_id_length_xor_deframer;
    import sidx_pkg::*;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic         kind;
        byte_t        pbyte;
        logic         last;
        frame_count_t good;
        frame_count_t bad;
    } frame_word_t;

    typedef struct packed {
        byte_t       data;
        logic        typed;
        frame_word_t want;
    } stim_row_t;

    // Reset settings: device ID 1, payload count 38.
    localparam stim_row_t RESET_ROWS [15] = '{
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, 1'b1, 16'd0, 16'd1}},
        '{8'hFF, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'hAA, 1'b1, '{KIND_ERROR, 8'h00, 1'b1, 16'd0, 16'd2}},
        '{8'hFF, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h04, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, 1'b1, 16'd0, 16'd3}}
    };

    // Device ID 0xFF, payload count 1.
    localparam stim_row_t ONE_BYTE_ROWS [12] = '{
        '{8'hFF, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 1'b1, 16'd1, 16'd3}},
        '{8'hFF, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'h34, 1'b1, '{KIND_ERROR, 8'h00, 1'b1, 16'd1, 16'd4}}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sidx_in_if  in_if ();
    sidx_out_if out_if ();

    sync_id_length_xor_deframer #(
        .MAX_PAYLOAD (PAYLOAD_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser state and register copies.
    byte_t        frame_pos;
    byte_t        decl_len;
    logic [6:0]   pay_cnt;
    byte_t        run_xor;
    byte_t        pay_store [PAYLOAD_DEPTH];
    frame_count_t good_cnt;
    frame_count_t bad_cnt;
    byte_t        cfg_id;
    exp_count_t   cfg_cnt;

    frame_word_t  parsed_words [$];
    frame_word_t  frame_words_due [$];
    byte_t        frame_bytes [$];

    int unsigned  fails;
    int unsigned  cycles;
    int unsigned  bytes_in;
    int unsigned  words_seen;
    int unsigned  hold_req;
    logic         steady;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d words still due", $time,
                     frame_words_due.size());
            $display("** sync_id_length_xor_deframer: FAILED **");
            $finish;
        end
    end

    function automatic void add_word(logic kind, byte_t pbyte, logic last);
        frame_word_t w;
        w.kind  = kind;
        w.pbyte = pbyte;
        w.last  = last;
        w.good  = good_cnt;
        w.bad   = bad_cnt;
        parsed_words.push_back(w);
    endfunction

    function automatic void parse_byte(byte_t b);
        logic ok;
        parsed_words.delete();
        if (frame_pos == POS_HUNT)
        begin
            decl_len = '0;
            if (b == SYNC_FIRST)
                frame_pos = POS_SYNC2;
        end
        else if (frame_pos == POS_SYNC2)
        begin
            if (b == SYNC_SECOND)
                frame_pos = POS_ID;
            else
            begin
                frame_pos = POS_HUNT;
                decl_len  = '0;
                bad_cnt++;
                add_word(KIND_ERROR, 8'h00, 1'b1);
            end
        end
        else if (frame_pos == POS_ID)
        begin
            frame_pos = (b == cfg_id) ? POS_LEN : POS_HUNT;
            decl_len  = '0;
        end
        else if (frame_pos == POS_LEN)
        begin
            decl_len  = b;
            frame_pos = POS_PAYLOAD;
            pay_cnt   = '0;
            run_xor   = '0;
        end
        else if (frame_pos < decl_len)
        begin
            if (pay_cnt < PAYLOAD_DEPTH)
            begin
                pay_store[pay_cnt[5:0]] = b;
                pay_cnt++;
            end
            else
                pay_cnt = 7'(PAYLOAD_DEPTH + 1);
            run_xor ^= b;
            frame_pos++;
        end
        else
        begin
            // The byte at or beyond the declared length is the checksum.
            ok = frame_pos == decl_len && decl_len != 0 && pay_cnt >= 1 &&
                 pay_cnt <= PAYLOAD_DEPTH && pay_cnt == cfg_cnt && b == run_xor;
            frame_pos = POS_HUNT;
            decl_len  = '0;
            if (!ok)
            begin
                bad_cnt++;
                add_word(KIND_ERROR, 8'h00, 1'b1);
            end
            else
            begin
                good_cnt++;
                for (int k = 0; k < pay_cnt; k++)
                    add_word(KIND_PAYLOAD, pay_store[k], k == pay_cnt - 1);
            end
        end
    endfunction

    function automatic void make_frame(byte_t id, int n, logic corrupt);
        byte_t x;
        byte_t b;
        x = '0;
        frame_bytes = '{SYNC_FIRST, SYNC_SECOND, id, byte_t'(n + 4)};
        repeat (n)
        begin
            b = byte_t'($urandom);
            x ^= b;
            frame_bytes.push_back(b);
        end
        if (corrupt)
            x ^= byte_t'($urandom_range(1, 255));
        frame_bytes.push_back(x);
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic push_byte(input byte_t value, input logic typed, input frame_word_t want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap != 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= value;
        do @(posedge clk); while (!in_if.ready);
        parse_byte(value);
        if (typed)
        begin
            parsed_words.delete();
            parsed_words.push_back(want);
        end
        foreach (parsed_words[k])
            frame_words_due.push_back(parsed_words[k]);
        bytes_in++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (frame_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input byte_t value, input byte_t mask);
        logic [31:0] wdata;
        logic [31:0] got;
        wdata = {24'($urandom_range(0, 32'hFFFFFF)), 8'h00} | 32'(value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        compare_field(idx == REG_DEVICE_ID ? "device_id readback" : "exp_count readback",
                      32'(value & mask), 32'(got[7:0] & mask));
    endtask

    task automatic set_config(input byte_t id, input exp_count_t cnt);
        reg_write(REG_DEVICE_ID, id, 8'hFF);
        reg_write(REG_EXP_COUNT, byte_t'(cnt), 8'h7F);
        cfg_id  = id;
        cfg_cnt = cnt;
    endtask

    task automatic send_frame_bytes();
        foreach (frame_bytes[k])
            push_byte(frame_bytes[k], 1'b0, '0);
    endtask

    task automatic run_phase(input byte_t id, input exp_count_t cnt, input int budget);
        int    sent;
        int    pick;
        int    n_good;
        byte_t v;
        set_config(id, cnt);
        sent = 0;
        while (sent < budget)
        begin
            pick   = $urandom_range(0, 99);
            n_good = (cfg_cnt >= 1 && cfg_cnt <= PAYLOAD_DEPTH) ? cfg_cnt : $urandom_range(1, 6);
            if (pick < 68)
                make_frame(cfg_id, n_good, 1'b0);
            else if (pick < 76)
                make_frame(cfg_id, n_good, 1'b1);
            else if (pick < 82)
                make_frame(cfg_id, $urandom_range(0, 8), 1'b0);
            else if (pick < 86)
                make_frame(cfg_id ^ byte_t'($urandom_range(1, 255)), n_good, 1'b0);
            else if (pick < 90)
            begin
                v = byte_t'($urandom_range(0, 254));
                if (v == SYNC_SECOND)
                    v = SYNC_FIRST;
                frame_bytes = '{SYNC_FIRST, v};
            end
            else if (pick < 95)
                frame_bytes = '{SYNC_FIRST, SYNC_SECOND, cfg_id,
                                byte_t'($urandom_range(0, 3)), byte_t'($urandom)};
            else
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 4))
                    frame_bytes.push_back(byte_t'($urandom));
            end
            if (pick < 95)
                sent += frame_bytes.size();
            send_frame_bytes();
        end
        while (frame_pos != POS_HUNT)
            push_byte(8'h00, 1'b0, '0);
        settle();
    endtask

    // Receiver: random ready gaps, one long hold on request, and the checker.
    initial
    begin
        int          stall;
        frame_word_t want;
        out_if.ready = 1'b0;
        forever
        begin
            if (hold_req != 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            else
                stall = steady ? 0 : $urandom_range(0, 6);
            repeat (stall)
            begin
                @(negedge clk);
                out_if.ready <= 1'b0;
            end
            @(negedge clk);
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!(out_if.valid && out_if.ready));
            words_seen++;
            if (frame_words_due.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected word, expected none, got %0h/%0h/%0h/%0h/%0h",
                         $time, out_if.item_kind, out_if.payload_byte,
                         out_if.last_of_frame, out_if.good_frames, out_if.bad_frames);
            end
            else
            begin
                want = frame_words_due.pop_front();
                compare_field("item_kind", want.kind, out_if.item_kind);
                compare_field("payload_byte", want.pbyte, out_if.payload_byte);
                compare_field("last_of_frame", want.last, out_if.last_of_frame);
                compare_field("good_frames", want.good, out_if.good_frames);
                compare_field("bad_frames", want.bad, out_if.bad_frames);
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        fails           = 0;
        cycles          = 0;
        bytes_in        = 0;
        words_seen      = 0;
        hold_req        = 0;
        steady          = 1'b0;
        frame_pos       = POS_HUNT;
        decl_len        = '0;
        pay_cnt         = '0;
        run_xor         = '0;
        good_cnt        = '0;
        bad_cnt         = '0;
        cfg_id          = DEVICE_ID_RST;
        cfg_cnt         = EXP_COUNT_RST;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (RESET_ROWS[i])
            push_byte(RESET_ROWS[i].data, RESET_ROWS[i].typed, RESET_ROWS[i].want);
        settle();
        set_config(8'hFF, 7'd1);
        foreach (ONE_BYTE_ROWS[i])
            push_byte(ONE_BYTE_ROWS[i].data, ONE_BYTE_ROWS[i].typed, ONE_BYTE_ROWS[i].want);
        settle();

        steady = 1'b1;
        run_phase(byte_t'($urandom), 7'd1, 8);
        steady = 1'b0;

        // Full buffer, then a frame that overruns it.
        set_config(8'h00, 7'd64);
        make_frame(8'h00, PAYLOAD_DEPTH, 1'b0);
        send_frame_bytes();
        make_frame(8'h00, PAYLOAD_DEPTH + 2, 1'b0);
        send_frame_bytes();
        settle();

        run_phase(8'hFF, 7'd0, 8);
        run_phase(8'hFE, 7'd127, 8);
        hold_req = 300;
        run_phase(byte_t'($urandom), 7'($urandom_range(1, 8)), 12);
        run_phase(byte_t'($urandom), 7'($urandom_range(1, 16)), 14);

        $display("Sent %0d bytes; %0d good and %0d rejected frames, %0d words checked.",
                 bytes_in, good_cnt, bad_cnt, words_seen);
        $display("Settings reached ID 0x00/0xFE/0xFF and payload counts 0, 1, 64, 127.");
        if (fails == 0)
            $display("** sync_id_length_xor_deframer: PASSED **");
        else
            $display("** sync_id_length_xor_deframer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
